>>> design/xsg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xsg_pkg
// Shared constants, codes and controller/datapath command types for the
// xoshiro256** generator core.
// ----------------------------------------------------------------------------
package xsg_pkg;

   localparam int WORD_WIDTH       = 64;
   localparam int HALF_WIDTH       = 32;
   localparam int WORD_COUNT       = 4;
   localparam int WORD_INDEX_WIDTH = 2;
   localparam int OP_WIDTH         = 2;
   localparam int BOUND_WIDTH      = 32;
   localparam int CSR_ADDR_WIDTH   = 4;
   localparam int CSR_DATA_WIDTH   = 64;
   localparam int CSR_INDEX_BIT    = 3;

   localparam logic CSR_SEED_INDEX = 1'b0;

   localparam logic [WORD_WIDTH-1:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [WORD_WIDTH-1:0] MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
   localparam logic [WORD_WIDTH-1:0] MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_RESEED  = 2'd0,
      OP_DRAW64  = 2'd1,
      OP_DRAW32  = 2'd2,
      OP_BOUNDED = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      MUL_LL    = 2'd0,
      MUL_LH    = 2'd1,
      MUL_HL    = 2'd2,
      MUL_BOUND = 2'd3
   } mul_src_type;

   typedef struct packed {
      logic                        item_load;
      logic                        acc_init;
      logic                        acc_zero;
      logic                        mix_add;
      logic                        mul_en;
      mul_src_type                 mul_src;
      logic                        const_b;
      logic                        prod_load;
      logic                        prod_add;
      logic                        mix_xor;
      logic                        mix_store;
      logic [WORD_INDEX_WIDTH-1:0] word_idx;
      logic                        fix_zero;
      logic                        advance;
      logic                        scramble;
      logic                        rsp_load;
   } xsg_cmd_type;

   typedef struct packed {
      op_type op;
      logic   out_busy;
   } xsg_status_type;

endpackage

>>> design/xsg_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xsg_csr
// APB-style register file holding the seed register.
// ----------------------------------------------------------------------------
module xsg_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [xsg_pkg::CSR_ADDR_WIDTH-1:0]   paddr,
   input  logic [xsg_pkg::CSR_DATA_WIDTH-1:0]   pwdata,
   output logic [xsg_pkg::CSR_DATA_WIDTH-1:0]   prdata,
   output logic                                 pready,
   output logic [xsg_pkg::WORD_WIDTH-1:0]       seed_value
);
   import xsg_pkg::*;

   logic [WORD_WIDTH-1:0] seed_ff;
   logic [WORD_WIDTH-1:0] seed_in;
   logic                  seed_sel;

   assign seed_sel = (paddr[CSR_INDEX_BIT] == CSR_SEED_INDEX);

   always_comb begin
      seed_in = seed_ff;
      if (psel && penable && pwrite && seed_sel) begin
         seed_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else begin
         seed_ff <= seed_in;
      end
   end

   assign prdata     = seed_sel ? seed_ff : '0;
   assign pready     = 1'b1;
   assign seed_value = seed_ff;

endmodule

>>> design/xsg_control.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xsg_control
// Sequencer for reseed expansion, draws and result hand-off.
// ----------------------------------------------------------------------------
module xsg_control (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic [xsg_pkg::OP_WIDTH-1:0]    req_operation,
   output logic                            req_ready,
   input  xsg_pkg::xsg_status_type         status,
   output xsg_pkg::xsg_cmd_type            cmd
);
   import xsg_pkg::*;

   typedef enum logic [3:0] {
      ST_BOOT,
      ST_IDLE,
      ST_MIX_ADD,
      ST_MUL_LL,
      ST_MUL_LH,
      ST_MUL_HL,
      ST_MUL_ACC,
      ST_MIX_XOR,
      ST_MIX_STORE,
      ST_FIX_ZERO,
      ST_DRAW,
      ST_SCRAMBLE,
      ST_BOUND_MUL,
      ST_FINISH
   } state_type;

   state_type                   state_ff, state_in;
   logic [WORD_INDEX_WIDTH-1:0] idx_ff, idx_in;
   logic                        half_ff, half_in;
   logic                        boot_ff, boot_in;
   logic                        accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      half_in  = half_ff;
      boot_in  = boot_ff;
      cmd      = '0;
      cmd.word_idx = idx_ff;
      cmd.const_b  = half_ff;
      case (state_ff)
         ST_BOOT: begin
            cmd.acc_init = 1'b1;
            cmd.acc_zero = 1'b1;
            idx_in   = '0;
            half_in  = 1'b0;
            boot_in  = 1'b1;
            state_in = ST_MIX_ADD;
         end
         ST_IDLE: begin
            if (accept) begin
               cmd.item_load = 1'b1;
               if (op_type'(req_operation) == OP_RESEED) begin
                  cmd.acc_init = 1'b1;
                  idx_in   = '0;
                  half_in  = 1'b0;
                  state_in = ST_MIX_ADD;
               end else begin
                  state_in = ST_DRAW;
               end
            end
         end
         ST_MIX_ADD: begin
            cmd.mix_add = 1'b1;
            state_in    = ST_MUL_LL;
         end
         ST_MUL_LL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_src = MUL_LL;
            state_in    = ST_MUL_LH;
         end
         ST_MUL_LH: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_src   = MUL_LH;
            cmd.prod_load = 1'b1;
            state_in      = ST_MUL_HL;
         end
         ST_MUL_HL: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_src  = MUL_HL;
            cmd.prod_add = 1'b1;
            state_in     = ST_MUL_ACC;
         end
         ST_MUL_ACC: begin
            cmd.prod_add = 1'b1;
            state_in     = half_ff ? ST_MIX_STORE : ST_MIX_XOR;
         end
         ST_MIX_XOR: begin
            cmd.mix_xor = 1'b1;
            half_in     = 1'b1;
            state_in    = ST_MUL_LL;
         end
         ST_MIX_STORE: begin
            cmd.mix_store = 1'b1;
            half_in       = 1'b0;
            idx_in        = idx_ff + 1'b1;
            if (idx_ff == WORD_INDEX_WIDTH'(WORD_COUNT - 1)) begin
               state_in = ST_FIX_ZERO;
            end else begin
               state_in = ST_MIX_ADD;
            end
         end
         ST_FIX_ZERO: begin
            cmd.fix_zero = 1'b1;
            boot_in      = 1'b0;
            state_in     = boot_ff ? ST_IDLE : ST_FINISH;
         end
         ST_DRAW: begin
            cmd.advance = 1'b1;
            state_in    = ST_SCRAMBLE;
         end
         ST_SCRAMBLE: begin
            cmd.scramble = 1'b1;
            state_in     = (status.op == OP_BOUNDED) ? ST_BOUND_MUL : ST_FINISH;
         end
         ST_BOUND_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_src = MUL_BOUND;
            state_in    = ST_FINISH;
         end
         ST_FINISH: begin
            if (!status.out_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_BOOT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_BOOT;
         idx_ff   <= '0;
         half_ff  <= 1'b0;
         boot_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         half_ff  <= half_in;
         boot_ff  <= boot_in;
      end
   end

endmodule

>>> design/xsg_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xsg_datapath
// Generator state, splitmix64 expansion with a shared 32x32 multiplier,
// scrambler, bounded multiply and result register.
// ----------------------------------------------------------------------------
module xsg_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  xsg_pkg::xsg_cmd_type               cmd,
   output xsg_pkg::xsg_status_type            status,
   input  logic [xsg_pkg::OP_WIDTH-1:0]       req_operation,
   input  logic [xsg_pkg::BOUND_WIDTH-1:0]    req_bound,
   input  logic [xsg_pkg::WORD_WIDTH-1:0]     seed_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [xsg_pkg::WORD_WIDTH-1:0]     rsp_value
);
   import xsg_pkg::*;

   function automatic logic [WORD_WIDTH-1:0] rotl64(input logic [WORD_WIDTH-1:0] w,
                                                    input int unsigned r);
      rotl64 = (w << r) | (w >> (WORD_WIDTH - r));
   endfunction

   logic [WORD_COUNT-1:0][WORD_WIDTH-1:0] state_ff, state_in;
   logic [WORD_WIDTH-1:0]   acc_ff, acc_in;
   logic [WORD_WIDTH-1:0]   z_ff, z_in;
   logic [WORD_WIDTH-1:0]   m_ff, m_in;
   logic [WORD_WIDTH-1:0]   p_ff, p_in;
   op_type                  op_ff, op_in;
   logic [BOUND_WIDTH-1:0]  bound_ff, bound_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [WORD_WIDTH-1:0]   rsp_value_ff, rsp_value_in;

   logic [WORD_WIDTH-1:0]   mul_const;
   logic [HALF_WIDTH-1:0]   mul_a, mul_b;
   logic [WORD_WIDTH-1:0]   acc_sum;
   logic [WORD_WIDTH-1:0]   s1_x5;
   logic [WORD_WIDTH-1:0]   adv_t, adv_n0, adv_n1, adv_n2, adv_n3;

   assign mul_const = cmd.const_b ? MIX_MUL_B : MIX_MUL_A;

   always_comb begin
      case (cmd.mul_src)
         MUL_LL: begin
            mul_a = z_ff[HALF_WIDTH-1:0];
            mul_b = mul_const[HALF_WIDTH-1:0];
         end
         MUL_LH: begin
            mul_a = z_ff[HALF_WIDTH-1:0];
            mul_b = mul_const[WORD_WIDTH-1:HALF_WIDTH];
         end
         MUL_HL: begin
            mul_a = z_ff[WORD_WIDTH-1:HALF_WIDTH];
            mul_b = mul_const[HALF_WIDTH-1:0];
         end
         MUL_BOUND: begin
            mul_a = m_ff[WORD_WIDTH-1:HALF_WIDTH];
            mul_b = bound_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign acc_sum = acc_ff + GOLDEN_GAMMA;
   assign s1_x5   = state_ff[1] + (state_ff[1] << 2);
   assign adv_t   = state_ff[1] << 17;
   assign adv_n2  = state_ff[2] ^ state_ff[0];
   assign adv_n3  = state_ff[3] ^ state_ff[1];
   assign adv_n1  = state_ff[1] ^ adv_n2;
   assign adv_n0  = state_ff[0] ^ adv_n3;

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      z_in         = z_ff;
      m_in         = m_ff;
      p_in         = p_ff;
      op_in        = op_ff;
      bound_in     = bound_ff;
      rsp_value_in = rsp_value_ff;
      rsp_valid_in = rsp_valid_ff;

      if (cmd.item_load) begin
         op_in    = op_type'(req_operation);
         bound_in = req_bound;
      end
      if (cmd.acc_init) begin
         acc_in = cmd.acc_zero ? '0 : seed_value;
      end
      if (cmd.mix_add) begin
         acc_in = acc_sum;
         z_in   = acc_sum ^ (acc_sum >> 30);
      end
      if (cmd.mix_xor) begin
         z_in = m_ff ^ (m_ff >> 27);
      end
      if (cmd.mul_en) begin
         p_in = {{HALF_WIDTH{1'b0}}, mul_a} * {{HALF_WIDTH{1'b0}}, mul_b};
      end
      if (cmd.prod_load) begin
         m_in = p_ff;
      end
      if (cmd.prod_add) begin
         m_in = {m_ff[WORD_WIDTH-1:HALF_WIDTH] + p_ff[HALF_WIDTH-1:0],
                 m_ff[HALF_WIDTH-1:0]};
      end
      if (cmd.mix_store) begin
         state_in[cmd.word_idx] = m_ff ^ (m_ff >> 31);
      end
      if (cmd.fix_zero) begin
         if ((state_ff[0] | state_ff[1] | state_ff[2] | state_ff[3]) == '0) begin
            state_in[0] = GOLDEN_GAMMA;
         end
      end
      if (cmd.advance) begin
         z_in        = rotl64(s1_x5, 7);
         state_in[0] = adv_n0;
         state_in[1] = adv_n1;
         state_in[2] = adv_n2 ^ adv_t;
         state_in[3] = rotl64(adv_n3, 45);
      end
      if (cmd.scramble) begin
         m_in = z_ff + (z_ff << 3);
      end

      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         case (op_ff)
            OP_RESEED:  rsp_value_in = '0;
            OP_DRAW64:  rsp_value_in = m_ff;
            OP_DRAW32:  rsp_value_in = {{HALF_WIDTH{1'b0}}, m_ff[WORD_WIDTH-1:HALF_WIDTH]};
            OP_BOUNDED: rsp_value_in = {{HALF_WIDTH{1'b0}}, p_ff[WORD_WIDTH-1:HALF_WIDTH]};
            default:    rsp_value_in = '0;
         endcase
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      state_ff     <= state_in;
      acc_ff       <= acc_in;
      z_ff         <= z_in;
      m_ff         <= m_in;
      p_ff         <= p_in;
      op_ff        <= op_in;
      bound_ff     <= bound_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign status.op       = op_ff;
   assign status.out_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_value       = rsp_value_ff;

endmodule

>>> design/xoshiro256ss_generator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xoshiro256ss_generator_core
// xoshiro256** generator with splitmix64 seeding and bounded draws.
// ----------------------------------------------------------------------------
// One item is in work at a time; the next is taken while a result waits on
// the output. A 64-bit or upper-32 draw runs the state update and the
// scrambler; a bounded draw makes one extra pass through the 32x32
// multiplier. In a reseed, each of the four splitmix64 steps runs two
// 64-bit constant multiplies as three partial products on the one shared
// 32x32 multiplier. After reset the block expands seed zero itself and
// holds req_ready low until done; the seed register may be written then.
module xoshiro256ss_generator_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [xsg_pkg::OP_WIDTH-1:0]         req_operation,
   input  logic [xsg_pkg::BOUND_WIDTH-1:0]      req_bound,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [xsg_pkg::WORD_WIDTH-1:0]       rsp_value,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [xsg_pkg::CSR_ADDR_WIDTH-1:0]   paddr,
   input  logic [xsg_pkg::CSR_DATA_WIDTH-1:0]   pwdata,
   output logic [xsg_pkg::CSR_DATA_WIDTH-1:0]   prdata,
   output logic                                 pready
);
   import xsg_pkg::*;

   logic [WORD_WIDTH-1:0] seed_value;
   xsg_cmd_type           cmd;
   xsg_status_type        status;

   xsg_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .seed_value (seed_value)
   );

   xsg_control u_control (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_ready     (req_ready),
      .status        (status),
      .cmd           (cmd)
   );

   xsg_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_operation (req_operation),
      .req_bound     (req_bound),
      .seed_value    (seed_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value     (rsp_value)
   );

endmodule

>>> design/xsg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xsg_checker
// Port-level checks for the generator core, bound to the top level.
// ----------------------------------------------------------------------------
module xsg_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic [xsg_pkg::WORD_WIDTH-1:0]       rsp_value
);
   import xsg_pkg::*;

   logic [2:0] pending_ff, pending_in;
   logic       req_xfer, rsp_xfer;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (req_xfer && !rsp_xfer) begin
         pending_in = pending_ff + 3'd1;
      end else if (!req_xfer && rsp_xfer) begin
         pending_in = pending_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value))
      else $error("result changed while stalled");

   // one item in work at a time
   assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_ready)
      else $error("request taken while busy");

   // at most one in work plus one waiting
   assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 3'd2)
      else $error("too many items outstanding");

   // no result without a request
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 3'd0)
      else $error("result with no outstanding request");

endmodule

bind xoshiro256ss_generator_core xsg_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_value (rsp_value)
);

>>> sim/xoshiro256ss_generator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xoshiro256ss_generator_core_tb
// Self-checking bench for the xoshiro256** generator core. A directed table
// covers the reset state, reseeds, bound extremes and back-to-back draws.
// Random draws then run under several seeds written through the register
// port. Every result is compared in order against a fixed value or a local
// predictor of the splitmix64 expansion and the xoshiro256** state update,
// with random idle bursts on both channels except in the last phase.
// ----------------------------------------------------------------------------
module xoshiro256ss_generator_core_tb;

   import xsg_pkg::*;

   localparam int CLOCK_HALF    = 6;
   localparam int RESET_CYCLES  = 6;
   localparam int PHASE_COUNT   = 8;
   localparam int PHASE_ITEMS   = 82;
   localparam int STALL_LIMIT   = 1000;
   localparam int DRAIN_CYCLES  = 60;
   localparam int PRINT_LIMIT   = 50;

   localparam logic [CSR_ADDR_WIDTH-1:0] SEED_ADDR  = 4'h0;
   localparam logic [CSR_ADDR_WIDTH-1:0] SPARE_ADDR = 4'h8;

   typedef struct packed {
      op_type                  op;
      logic [BOUND_WIDTH-1:0]  bound;
      logic                    fixed;
      logic [WORD_WIDTH-1:0]   value;
   } draw_row_type;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic [OP_WIDTH-1:0]         req_operation;
   logic [BOUND_WIDTH-1:0]      req_bound;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic [WORD_WIDTH-1:0]       rsp_value;
   logic                        psel;
   logic                        penable;
   logic                        pwrite;
   logic [CSR_ADDR_WIDTH-1:0]   paddr;
   logic [CSR_DATA_WIDTH-1:0]   pwdata;
   logic [CSR_DATA_WIDTH-1:0]   prdata;
   logic                        pready;

   logic [WORD_WIDTH-1:0]       gen_word [WORD_COUNT];
   logic [WORD_WIDTH-1:0]       seed_reg;
   logic [WORD_WIDTH-1:0]       pending_draws [$];
   logic [WORD_WIDTH-1:0]       oldest_draw;
   draw_row_type                directed_rows [$];
   int                          error_count;
   int                          stall_cycles;
   bit                          quiet_mode;

   xoshiro256ss_generator_core u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_bound     (req_bound),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value     (rsp_value),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   function automatic void expand_seed(input logic [WORD_WIDTH-1:0] sd);
      logic [WORD_WIDTH-1:0] acc;
      logic [WORD_WIDTH-1:0] z;
      acc = sd;
      for (int i = 0; i < WORD_COUNT; i++) begin
         acc = acc + GOLDEN_GAMMA;
         z = acc;
         z = (z ^ (z >> 30)) * MIX_MUL_A;
         z = (z ^ (z >> 27)) * MIX_MUL_B;
         gen_word[i] = z ^ (z >> 31);
      end
      if ((gen_word[0] | gen_word[1] | gen_word[2] | gen_word[3]) == '0) begin
         gen_word[0] = GOLDEN_GAMMA;
      end
   endfunction

   function automatic logic [WORD_WIDTH-1:0] next_draw();
      logic [WORD_WIDTH-1:0] times5;
      logic [WORD_WIDTH-1:0] scrambled;
      logic [WORD_WIDTH-1:0] t;
      times5    = gen_word[1] * 64'd5;
      scrambled = {times5[56:0], times5[63:57]} * 64'd9;
      t         = gen_word[1] << 17;
      gen_word[2] = gen_word[2] ^ gen_word[0];
      gen_word[3] = gen_word[3] ^ gen_word[1];
      gen_word[1] = gen_word[1] ^ gen_word[2];
      gen_word[0] = gen_word[0] ^ gen_word[3];
      gen_word[2] = gen_word[2] ^ t;
      gen_word[3] = {gen_word[3][18:0], gen_word[3][63:19]};
      return scrambled;
   endfunction

   function automatic logic [WORD_WIDTH-1:0] predict_value(input op_type op,
                                                           input logic [BOUND_WIDTH-1:0] bnd);
      logic [WORD_WIDTH-1:0] draw;
      logic [WORD_WIDTH-1:0] product;
      draw = '0;
      case (op)
         OP_RESEED: begin
            expand_seed(seed_reg);
         end
         OP_DRAW64: begin
            draw = next_draw();
         end
         OP_DRAW32: begin
            product = next_draw();
            draw = {32'd0, product[63:32]};
         end
         default: begin
            product = next_draw();
            product = {32'd0, product[63:32]} * {32'd0, bnd};
            draw = {32'd0, product[63:32]};
         end
      endcase
      return draw;
   endfunction

   task automatic report_mismatch(input string what, input logic [WORD_WIDTH-1:0] want,
                                  input logic [WORD_WIDTH-1:0] got);
      error_count++;
      if (error_count <= PRINT_LIMIT) begin
         $display("mismatch %0s: expected %h got %h at %0t", what, want, got, $time);
      end
   endtask

   task automatic send_item(input op_type op, input logic [BOUND_WIDTH-1:0] bnd,
                            input logic fixed, input logic [WORD_WIDTH-1:0] fixed_value);
      logic [WORD_WIDTH-1:0] predicted;
      if (!quiet_mode && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_bound     <= bnd;
      do @(posedge clock); while (!req_ready);
      predicted = predict_value(op, bnd);
      pending_draws.push_back(fixed ? fixed_value : predicted);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_WIDTH-1:0] addr,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_seed_readback(input logic [CSR_DATA_WIDTH-1:0] want);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= SEED_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== want) begin
         report_mismatch("seed readback", want, prdata);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // result channel backpressure
   initial begin
      int hold;
      rsp_ready = 1'b0;
      hold = 0;
      forever begin
         @(posedge clock);
         if (quiet_mode) begin
            rsp_ready <= 1'b1;
            hold = 0;
         end else if (hold > 0) begin
            hold--;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            hold = $urandom_range(1, 18) - 1;
         end else begin
            rsp_ready <= 1'b1;
            hold = $urandom_range(0, 30);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_draws.size() == 0) begin
            report_mismatch("unexpected result", '0, rsp_value);
         end else begin
            oldest_draw = pending_draws.pop_front();
            if (rsp_value !== oldest_draw) begin
               report_mismatch("value", oldest_draw, rsp_value);
            end
         end
      end
   end

   initial begin
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || psel) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
      end
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      logic [WORD_WIDTH-1:0]  seed;
      logic [BOUND_WIDTH-1:0] bnd;
      op_type                 op;
      int                     pick;

      reset         = 1'b1;
      req_valid     = 1'b0;
      req_operation = OP_RESEED;
      req_bound     = '0;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = SEED_ADDR;
      pwdata        = '0;
      quiet_mode    = 1'b0;
      error_count   = 0;
      seed_reg      = '0;
      expand_seed('0);

      // draws from the reset state, reseed results and bound extremes
      directed_rows.push_back('{OP_DRAW64,  32'd0,          1'b0, 64'd0});
      directed_rows.push_back('{OP_DRAW32,  32'd0,          1'b0, 64'd0});
      directed_rows.push_back('{OP_BOUNDED, 32'd0,          1'b1, 64'd0});
      directed_rows.push_back('{OP_BOUNDED, 32'd1,          1'b1, 64'd0});
      directed_rows.push_back('{OP_BOUNDED, 32'hFFFF_FFFF,  1'b0, 64'd0});
      directed_rows.push_back('{OP_BOUNDED, 32'h8000_0000,  1'b0, 64'd0});
      directed_rows.push_back('{OP_BOUNDED, 32'd2,          1'b0, 64'd0});
      directed_rows.push_back('{OP_RESEED,  32'hFFFF_FFFF,  1'b1, 64'd0});
      directed_rows.push_back('{OP_DRAW64,  32'hFFFF_FFFF,  1'b0, 64'd0});
      directed_rows.push_back('{OP_DRAW32,  32'd0,          1'b0, 64'd0});
      directed_rows.push_back('{OP_BOUNDED, 32'd0,          1'b1, 64'd0});
      directed_rows.push_back('{OP_DRAW64,  32'd0,          1'b0, 64'd0});
      directed_rows.push_back('{OP_DRAW64,  32'd0,          1'b0, 64'd0});
      directed_rows.push_back('{OP_RESEED,  32'd0,          1'b1, 64'd0});
      directed_rows.push_back('{OP_RESEED,  32'd0,          1'b1, 64'd0});
      directed_rows.push_back('{OP_BOUNDED, 32'd3,          1'b0, 64'd0});
      directed_rows.push_back('{OP_DRAW32,  32'hAAAA_5555,  1'b0, 64'd0});
      directed_rows.push_back('{OP_BOUNDED, 32'd1,          1'b1, 64'd0});

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].op, directed_rows[i].bound,
                   directed_rows[i].fixed, directed_rows[i].value);
      end

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         req_valid <= 1'b0;
         while (pending_draws.size() != 0) @(posedge clock);
         quiet_mode = (phase == PHASE_COUNT - 1);
         case (phase)
            0:       seed = '1;
            1:       seed = 64'd1;
            2:       seed = 64'h8000_0000_0000_0000;
            3:       seed = '0;
            default: seed = {$urandom, $urandom};
         endcase
         write_csr(SEED_ADDR, seed);
         seed_reg = seed;
         if (phase == 2 || phase == 5) begin
            write_csr(SPARE_ADDR, {$urandom, $urandom});
         end
         check_seed_readback(seed_reg);
         send_item(OP_RESEED, $urandom, 1'b1, '0);
         for (int n = 1; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
               op = OP_RESEED;
            end else if (pick < 35) begin
               op = OP_DRAW64;
            end else if (pick < 65) begin
               op = OP_DRAW32;
            end else begin
               op = OP_BOUNDED;
            end
            case ($urandom_range(0, 7))
               0:       bnd = 32'd0;
               1:       bnd = 32'd1;
               2:       bnd = 32'hFFFF_FFFF;
               3:       bnd = $urandom_range(2, 16);
               default: bnd = $urandom;
            endcase
            send_item(op, bnd, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (pending_draws.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
design/xsg_pkg.sv
design/xsg_csr.sv
design/xsg_control.sv
design/xsg_datapath.sv
design/xoshiro256ss_generator_core.sv
design/xsg_checker.sv
sim/xoshiro256ss_generator_core_tb.sv
